// ===== sv/source_text_tokenizer_assert.svh =====
// ----------------------------------------------------------------------------
// Source text tokenizer assertion macros
// Shared check macros, clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define STT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("source_text_tokenizer: check failed");
`define STT_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("source_text_tokenizer: check failed");
`else
`define STT_ASSERT(lbl, prop)
`define STT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== sv/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Default sizes, token codes, character codes and the keyword table.
// ----------------------------------------------------------------------------
package stt_pkg;

   // Default sizes handed to the top level parameters.
   localparam int MAX_TOKEN_LENGTH_DEF = 256;
   localparam int POSITION_BITS_DEF    = 24;
   localparam int LINE_BITS_DEF        = 16;

   // Depth of the token queue between scanner and emitter.
   localparam int QUEUE_DEPTH = 4;

   // Fixed field widths of a token word.
   localparam int KIND_BITS = 3;
   localparam int SYM_BITS  = 8;
   localparam int KWI_BITS  = 3;

   // Token kinds.
   localparam logic [KIND_BITS-1:0] KIND_SYMBOL   = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_STRING   = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_IDENT    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_SYNTAX   = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_DATATYPE = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_INTEGER  = 3'd5;

   // Keyword indexes.
   localparam logic [KWI_BITS-1:0] KWI_NONE   = 3'd0;
   localparam logic [KWI_BITS-1:0] KWI_VAR    = 3'd1;
   localparam logic [KWI_BITS-1:0] KWI_PRINT  = 3'd2;
   localparam logic [KWI_BITS-1:0] KWI_CONST  = 3'd3;
   localparam logic [KWI_BITS-1:0] KWI_STRING = 3'd4;
   localparam logic [KWI_BITS-1:0] KWI_INT    = 3'd5;

   // Character codes.
   localparam logic [7:0] CHAR_LF         = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE      = 8'h22;
   localparam logic [7:0] CHAR_LPAREN     = 8'h28;
   localparam logic [7:0] CHAR_RPAREN     = 8'h29;
   localparam logic [7:0] CHAR_STAR       = 8'h2A;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;
   localparam logic [7:0] CHAR_SEMI       = 8'h3B;
   localparam logic [7:0] CHAR_EQUAL      = 8'h3D;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CHAR_PAD        = 8'h00;

   // Keyword table, in keyword index order, padded to eight characters.
   localparam int KW_COUNT = 5;
   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{"v", "a", "r", CHAR_PAD, CHAR_PAD, CHAR_PAD, CHAR_PAD, CHAR_PAD},
      '{"p", "r", "i", "n", "t", CHAR_PAD, CHAR_PAD, CHAR_PAD},
      '{"c", "o", "n", "s", "t", CHAR_PAD, CHAR_PAD, CHAR_PAD},
      '{"s", "t", "r", "i", "n", "g", CHAR_PAD, CHAR_PAD},
      '{"i", "n", "t", CHAR_PAD, CHAR_PAD, CHAR_PAD, CHAR_PAD, CHAR_PAD}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd5, 3'd5, 3'd6, 3'd3};

   // Handshake status of one queue entry: present, and holding two tokens.
   typedef struct packed {
      logic valid;
      logic pair;
   } stt_entry_ctl_type;

endpackage

// ===== sv/stt_scan.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer scanner
// Classifies each accepted byte, tracks the open token and builds up to two
// token words per byte for the queue.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_assert.svh"

module stt_scan
   import stt_pkg::*;
#(
   parameter int MAX_TOKEN_LENGTH = MAX_TOKEN_LENGTH_DEF,
   parameter int POSITION_BITS    = POSITION_BITS_DEF,
   parameter int LINE_BITS        = LINE_BITS_DEF,
   parameter int LEN_BITS         = $clog2(MAX_TOKEN_LENGTH + 1),
   parameter int TOK_BITS         = KIND_BITS + POSITION_BITS + LEN_BITS + LINE_BITS +
                                    SYM_BITS + KWI_BITS + 1
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_accept,
   input  logic [7:0]            text_byte,
   input  logic                  end_of_text,
   output stt_entry_ctl_type     push_ctl,
   output logic [TOK_BITS-1:0]   first_tok,
   output logic [TOK_BITS-1:0]   second_tok
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_STRING,
      MODE_WORD,
      MODE_NUMBER
   } mode_type;

   localparam logic [LEN_BITS-1:0]      LEN_MAX  = LEN_BITS'(MAX_TOKEN_LENGTH);
   localparam logic [LINE_BITS-1:0]     LINE_ONE = LINE_BITS'(1);
   localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);

   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic [POSITION_BITS-1:0] tstart_ff, tstart_in;
   logic [LINE_BITS-1:0]     tline_ff, tline_in;
   logic [LEN_BITS-1:0]      count_ff, count_in;
   logic [KW_COUNT-1:0]      match_ff, match_in;
   logic                     ovf_ff, ovf_in;

   logic is_letter, is_digit, is_symbol, is_quote;
   logic in_string, in_word, in_number;
   logic used, close_cur, opening, do_add, flush;
   logic [LEN_BITS-1:0]  base_count, add_count;
   logic [KW_COUNT-1:0]  base_match, add_match;
   logic                 base_ovf, add_ovf;
   logic [TOK_BITS-1:0]  closed_tok, flush_tok, sym_tok;

   // Packs one token word, kind in the lowest bits.
   function automatic logic [TOK_BITS-1:0] pack_tok(
      input logic [KIND_BITS-1:0]     kind,
      input logic [POSITION_BITS-1:0] start,
      input logic [LEN_BITS-1:0]      len,
      input logic [LINE_BITS-1:0]     line,
      input logic [SYM_BITS-1:0]      sym,
      input logic [KWI_BITS-1:0]      kwi,
      input logic                     ovf
   );
      return {ovf, kwi, sym, line, len, start, kind};
   endfunction

   // Builds the word for a string, word or number token from its state.
   function automatic logic [TOK_BITS-1:0] value_tok(
      input mode_type                 mode,
      input logic [POSITION_BITS-1:0] start,
      input logic [LINE_BITS-1:0]     line,
      input logic [LEN_BITS-1:0]      cnt,
      input logic [KW_COUNT-1:0]      match,
      input logic                     ovf
   );
      logic [KWI_BITS-1:0]  kwi;
      logic [KIND_BITS-1:0] kind;
      kwi = KWI_NONE;
      if (mode == MODE_WORD) begin
         // The lowest matching keyword wins.
         for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (match[k] && cnt == LEN_BITS'(KW_LEN[k]) && !ovf) begin
               kwi = KWI_BITS'(k + 1);
            end
         end
      end
      case (mode)
         MODE_STRING: kind = KIND_STRING;
         MODE_WORD: begin
            if (kwi == KWI_NONE) begin
               kind = KIND_IDENT;
            end else if (kwi <= KWI_PRINT) begin
               kind = KIND_SYNTAX;
            end else begin
               kind = KIND_DATATYPE;
            end
         end
         default: kind = KIND_INTEGER;
      endcase
      return pack_tok(kind, start, cnt, line, CHAR_PAD, kwi, ovf);
   endfunction

   // Byte classes.
   always_comb begin
      is_letter = (text_byte inside {[CHAR_LOWER_A:CHAR_LOWER_Z], [CHAR_UPPER_A:CHAR_UPPER_Z],
                                     CHAR_UNDERSCORE});
      is_digit  = (text_byte inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]});
      is_symbol = (text_byte inside {CHAR_LPAREN, CHAR_RPAREN, CHAR_EQUAL, CHAR_SEMI,
                                     CHAR_PLUS, CHAR_MINUS, CHAR_SLASH, CHAR_STAR});
      is_quote  = (text_byte == CHAR_QUOTE);
   end

   // Decide what the byte does to the open token.
   always_comb begin
      in_string = (mode_ff == MODE_STRING);
      in_word   = (mode_ff == MODE_WORD);
      in_number = (mode_ff == MODE_NUMBER);
      used      = in_string || (in_word && (is_letter || is_digit)) ||
                  (in_number && is_digit);
      close_cur = (in_string && is_quote) || (in_word && !(is_letter || is_digit)) ||
                  (in_number && !is_digit);
      opening   = !used && (is_quote || is_letter || is_digit);
      do_add    = (used && !(in_string && is_quote)) || (opening && !is_quote);
   end

   // Character append with per-keyword match flags.
   always_comb begin
      if (opening) begin
         base_count = '0;
         base_match = '1;
         base_ovf   = 1'b0;
      end else begin
         base_count = count_ff;
         base_match = match_ff;
         base_ovf   = ovf_ff;
      end
      if (base_count == LEN_MAX) begin
         add_count = base_count;
         add_match = '0;
         add_ovf   = 1'b1;
      end else begin
         for (int k = 0; k < KW_COUNT; k++) begin
            add_match[k] = base_match[k] && (base_count < LEN_BITS'(KW_LEN[k])) &&
                           (KW_TEXT[k][base_count[2:0]] == text_byte);
         end
         add_count = base_count + 1'b1;
         add_ovf   = base_ovf;
      end
   end

   // Token state after this byte, before the end of text is applied.
   always_comb begin
      if (used) begin
         mode_in = (in_string && is_quote) ? MODE_IDLE : mode_ff;
      end else if (opening) begin
         if (is_quote) begin
            mode_in = MODE_STRING;
         end else if (is_letter) begin
            mode_in = MODE_WORD;
         end else begin
            mode_in = MODE_NUMBER;
         end
      end else begin
         mode_in = MODE_IDLE;
      end
      if (opening) begin
         tstart_in = is_quote ? (pos_ff + POS_ONE) : pos_ff;
         tline_in  = line_ff;
      end else begin
         tstart_in = tstart_ff;
         tline_in  = tline_ff;
      end
      if (do_add) begin
         count_in = add_count;
         match_in = add_match;
         ovf_in   = add_ovf;
      end else begin
         count_in = base_count;
         match_in = base_match;
         ovf_in   = base_ovf;
      end
      pos_in  = pos_ff + POS_ONE;
      line_in = ((text_byte == CHAR_LF) && (line_ff != '1)) ? (line_ff + LINE_ONE) : line_ff;
   end

   // Result words in order: closed token, symbol, flushed token.
   always_comb begin
      flush      = end_of_text && (mode_in != MODE_IDLE);
      closed_tok = value_tok(mode_ff, tstart_ff, tline_ff, count_ff, match_ff, ovf_ff);
      flush_tok  = value_tok(mode_in, tstart_in, tline_in, count_in, match_in, ovf_in);
      sym_tok    = pack_tok(KIND_SYMBOL, pos_ff, LEN_BITS'(1), line_ff, text_byte,
                            KWI_NONE, 1'b0);
      if (close_cur) begin
         first_tok = closed_tok;
      end else if (is_symbol && !used) begin
         first_tok = sym_tok;
      end else begin
         first_tok = flush_tok;
      end
      second_tok     = (is_symbol && !used) ? sym_tok : flush_tok;
      push_ctl.valid = byte_accept && (close_cur || (is_symbol && !used) || flush);
      push_ctl.pair  = close_cur && ((is_symbol && !used) || flush);
   end

   // Scanner state; the end of text returns everything to its reset value.
   always_ff @(posedge clock) begin
      if (reset || (byte_accept && end_of_text)) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         line_ff   <= LINE_ONE;
         tstart_ff <= '0;
         tline_ff  <= LINE_ONE;
         count_ff  <= '0;
         match_ff  <= '1;
         ovf_ff    <= 1'b0;
      end else if (byte_accept) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         tstart_ff <= tstart_in;
         tline_ff  <= tline_in;
         count_ff  <= count_in;
         match_ff  <= match_in;
         ovf_ff    <= ovf_in;
      end
   end

   `STT_ASSERT(a_scan_count_bound, count_ff <= LEN_MAX)
   `STT_ASSERT_NEXT(a_scan_eot_clears, byte_accept && end_of_text,
                    mode_ff == MODE_IDLE && line_ff == LINE_ONE && pos_ff == '0)

endmodule

// ===== sv/stt_queue.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer queue
// Short queue of scanner results, each entry holding one or two token words.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_assert.svh"

module stt_queue
   import stt_pkg::*;
#(
   parameter int TOK_BITS = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  stt_entry_ctl_type     push_ctl,
   input  logic [TOK_BITS-1:0]   push_first,
   input  logic [TOK_BITS-1:0]   push_second,
   output logic                  space,
   output stt_entry_ctl_type     head_ctl,
   output logic [TOK_BITS-1:0]   head_first,
   output logic [TOK_BITS-1:0]   head_second,
   input  logic                  pop
);

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(QUEUE_DEPTH);

   logic [TOK_BITS-1:0]   first_ff  [QUEUE_DEPTH];
   logic [TOK_BITS-1:0]   second_ff [QUEUE_DEPTH];
   logic                  pair_ff   [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_BITS-1:0] count_ff;

   // Head of the queue.
   always_comb begin
      space          = (count_ff != COUNT_FULL);
      head_ctl.valid = (count_ff != '0);
      head_ctl.pair  = pair_ff[rd_ptr_ff];
      head_first     = first_ff[rd_ptr_ff];
      head_second    = second_ff[rd_ptr_ff];
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_ctl.valid) begin
         first_ff[wr_ptr_ff]  <= push_first;
         second_ff[wr_ptr_ff] <= push_second;
         pair_ff[wr_ptr_ff]   <= push_ctl.pair;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ctl.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push_ctl.valid && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push_ctl.valid) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `STT_ASSERT(a_queue_no_overrun, !push_ctl.valid || (count_ff != COUNT_FULL))
   `STT_ASSERT(a_queue_no_underrun, !pop || (count_ff != '0))

endmodule

// ===== sv/stt_emit.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer emitter
// Takes queue entries apart into single tokens and holds each in the output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_assert.svh"

module stt_emit
   import stt_pkg::*;
#(
   parameter int TOK_BITS  = 64,
   parameter int DATA_BITS = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  stt_entry_ctl_type     head_ctl,
   input  logic [TOK_BITS-1:0]   head_first,
   input  logic [TOK_BITS-1:0]   head_second,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_BITS-1:0]  rsp_tdata,
   output logic                  rsp_tlast
);

   logic                valid_ff;
   logic                slot_ff, slot_in;
   logic [TOK_BITS-1:0] data_ff, data_in;
   logic                last_ff, last_in;
   logic                load, split;

   // Load the output register whenever it is empty or being taken.
   always_comb begin
      load  = head_ctl.valid && (!valid_ff || rsp_tready);
      split = head_ctl.pair && !slot_ff;
      pop   = load && !split;
      if (split) begin
         data_in = head_first;
         last_in = 1'b0;
         slot_in = 1'b1;
      end else begin
         data_in = slot_ff ? head_second : head_first;
         last_in = 1'b1;
         slot_in = 1'b0;
      end
   end

   // Control state of the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
         slot_ff  <= slot_in;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   // Output word.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = DATA_BITS'(data_ff);
   assign rsp_tlast  = last_ff;

   `STT_ASSERT(a_emit_second_half, !slot_ff || (head_ctl.valid && head_ctl.pair))

endmodule

// ===== sv/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer
// Turns a byte stream of source text into a stream of token descriptors.
// ----------------------------------------------------------------------------
// Usage: source text enters on the req_ channel, one byte per word, with
// req_tlast set on the final byte of a text. Token descriptors leave on the
// rsp_ channel, one token per word, with rsp_tlast set on the last token
// caused by a given input byte. A byte causes zero, one or two tokens.
// A token passes from the scanner into a queue entry and then into the output
// register before it appears on rsp_tvalid.
// Throughput: one byte per cycle while bytes cause at most one token each
// and the receiver does not stall; the output register drains one token per
// cycle, so a byte that causes two tokens holds its queue entry until both
// are loaded into the output register, which the four-entry queue absorbs.
// When the receiver stalls, the queue fills and req_tready drops once all
// four entries are held; the output word stays stable until taken.
// After reset, and after every byte marked req_tlast, the scanner is outside
// any token with position zero and line one. After reset the queue and the
// output register are also empty.
// ----------------------------------------------------------------------------
module source_text_tokenizer
   import stt_pkg::*;
#(
   parameter int MAX_TOKEN_LENGTH = MAX_TOKEN_LENGTH_DEF,
   parameter int POSITION_BITS    = POSITION_BITS_DEF,
   parameter int LINE_BITS        = LINE_BITS_DEF,
   localparam int LEN_BITS        = $clog2(MAX_TOKEN_LENGTH + 1),
   localparam int TOK_BITS        = KIND_BITS + POSITION_BITS + LEN_BITS + LINE_BITS +
                                    SYM_BITS + KWI_BITS + 1,
   localparam int DATA_BITS       = ((TOK_BITS + 7) / 8) * 8
)
(
   input  logic                 clock,
   input  logic                 reset,
   // Source text bytes.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // text_byte
   input  logic                 req_tlast,   // end_of_text
   // Token descriptors.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // token_kind, start_position, token_length, start_line, symbol_byte,
   // keyword_index, length_overflow, then zero fill
   output logic [DATA_BITS-1:0] rsp_tdata,
   output logic                 rsp_tlast    // last_of_run
);

   stt_entry_ctl_type   push_ctl, head_ctl;
   logic [TOK_BITS-1:0] push_first, push_second, head_first, head_second;
   logic                space, pop, byte_accept;

   // A byte is taken whenever the queue has room for its results.
   assign req_tready  = space;
   assign byte_accept = req_tvalid && space;

   stt_scan #(
      .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
      .POSITION_BITS    (POSITION_BITS),
      .LINE_BITS        (LINE_BITS),
      .LEN_BITS         (LEN_BITS),
      .TOK_BITS         (TOK_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .push_ctl    (push_ctl),
      .first_tok   (push_first),
      .second_tok  (push_second)
   );

   stt_queue #(
      .TOK_BITS (TOK_BITS)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_ctl    (push_ctl),
      .push_first  (push_first),
      .push_second (push_second),
      .space       (space),
      .head_ctl    (head_ctl),
      .head_first  (head_first),
      .head_second (head_second),
      .pop         (pop)
   );

   stt_emit #(
      .TOK_BITS  (TOK_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .head_ctl    (head_ctl),
      .head_first  (head_first),
      .head_second (head_second),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== dv/token_checker.sv =====
// ----------------------------------------------------------------------------
// Token stream checker
// Watches the byte and token channels of the source text tokenizer. Every
// accepted byte is run through an independent scanner that queues the token
// words it should cause. Every accepted token word is compared field by
// field with the oldest queued word.
// ----------------------------------------------------------------------------
module token_checker
   import stt_pkg::*;
#(
   parameter int DATA_W = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [7:0]        req_tdata,   // text_byte
   input  logic              req_tlast,   // end_of_text
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   // token_kind, start_position, token_length, start_line, symbol_byte,
   // keyword_index, length_overflow, then zero fill
   input  logic [DATA_W-1:0] rsp_tdata,
   input  logic              rsp_tlast,   // last_of_run
   output int                failures,
   output int                pending,
   output int                tokens_checked,
   output int                overflow_tokens,
   output logic [5:0]        kinds_seen,
   output logic [5:0]        keywords_seen,
   output logic [15:0]       top_line
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEN = MAX_TOKEN_LENGTH_DEF;
   localparam int POS_W   = POSITION_BITS_DEF;
   localparam int LINE_W  = LINE_BITS_DEF;
   localparam int LEN_W   = $clog2(MAX_LEN + 1);

   // Token word as it sits in rsp_tdata, token_kind in the lowest bits.
   typedef struct packed {
      logic                ovf;
      logic [KWI_BITS-1:0] kwi;
      logic [SYM_BITS-1:0] sym;
      logic [LINE_W-1:0]   line;
      logic [LEN_W-1:0]    len;
      logic [POS_W-1:0]    start;
      logic [KIND_BITS-1:0] kind;
   } token_word_type;

   localparam int TOK_W = $bits(token_word_type);

   typedef struct packed {
      logic           last;
      token_word_type word;
   } token_expect_type;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_STRING,
      SCAN_WORD,
      SCAN_NUMBER
   } scan_state_type;

   // Scanner state of the prediction.
   scan_state_type    scan_state;
   logic [POS_W-1:0]  text_offset;
   logic [POS_W-1:0]  tok_start;
   logic [LINE_W-1:0] line_count;
   logic [LINE_W-1:0] tok_line;
   logic [LEN_W-1:0]  tok_chars;
   logic [63:0]       tok_text;
   logic              tok_too_long;

   token_expect_type tokens_due[$];
   token_expect_type new_tokens[$];

   int                fail_count    = 0;
   int                checked_count = 0;
   int                long_count    = 0;
   logic [5:0]        kind_mask     = '0;
   logic [5:0]        keyword_mask  = '0;
   logic [LINE_W-1:0] line_peak     = '0;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) || c == CHAR_UNDERSCORE;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9;
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return c == CHAR_LPAREN || c == CHAR_RPAREN || c == CHAR_EQUAL ||
             c == CHAR_SEMI || c == CHAR_PLUS || c == CHAR_MINUS ||
             c == CHAR_SLASH || c == CHAR_STAR;
   endfunction

   // Keywords are recognized from the last eight characters of the word;
   // letters are never zero, so a shorter match needs the exact length.
   function automatic logic [KWI_BITS-1:0] keyword_of();
      if (tok_too_long) return KWI_NONE;
      if (tok_text == "var") return KWI_VAR;
      if (tok_text == "print") return KWI_PRINT;
      if (tok_text == "const") return KWI_CONST;
      if (tok_text == "string") return KWI_STRING;
      if (tok_text == "int") return KWI_INT;
      return KWI_NONE;
   endfunction

   task automatic restart_text();
      scan_state   = SCAN_IDLE;
      text_offset  = '0;
      line_count   = LINE_W'(1);
      tok_start    = '0;
      tok_line     = LINE_W'(1);
      tok_chars    = '0;
      tok_text     = '0;
      tok_too_long = 1'b0;
   endtask

   task automatic begin_token(input logic [POS_W-1:0] start, input scan_state_type mode);
      scan_state   = mode;
      tok_start    = start;
      tok_line     = line_count;
      tok_chars    = '0;
      tok_text     = '0;
      tok_too_long = 1'b0;
   endtask

   // Characters past the maximum length are dropped and only flagged.
   task automatic take_char(input logic [7:0] c);
      if (tok_chars >= MAX_LEN) begin
         tok_too_long = 1'b1;
      end else begin
         tok_chars = tok_chars + 1'b1;
         tok_text  = {tok_text[55:0], c};
      end
   endtask

   task automatic finish_token();
      token_expect_type t;
      t            = '0;
      t.word.start = tok_start;
      t.word.len   = tok_chars;
      t.word.line  = tok_line;
      t.word.ovf   = tok_too_long;
      case (scan_state)
         SCAN_STRING: t.word.kind = KIND_STRING;
         SCAN_NUMBER: t.word.kind = KIND_INTEGER;
         default: begin
            t.word.kwi = keyword_of();
            if (t.word.kwi == KWI_NONE)
               t.word.kind = KIND_IDENT;
            else if (t.word.kwi == KWI_VAR || t.word.kwi == KWI_PRINT)
               t.word.kind = KIND_SYNTAX;
            else
               t.word.kind = KIND_DATATYPE;
         end
      endcase
      new_tokens.push_back(t);
      scan_state = SCAN_IDLE;
   endtask

   // Predict the token words caused by one accepted byte.
   task automatic scan_byte(input logic [7:0] c, input logic eot);
      logic             consumed;
      token_expect_type t;
      consumed = 1'b0;
      new_tokens.delete();
      case (scan_state)
         SCAN_STRING: begin
            consumed = 1'b1;
            if (c == CHAR_QUOTE)
               finish_token();
            else
               take_char(c);
         end
         SCAN_WORD: begin
            if (is_letter(c) || is_digit(c)) begin
               take_char(c);
               consumed = 1'b1;
            end else begin
               finish_token();
            end
         end
         SCAN_NUMBER: begin
            if (is_digit(c)) begin
               take_char(c);
               consumed = 1'b1;
            end else begin
               finish_token();
            end
         end
         default: ;
      endcase

      // A byte that did not extend a token may start one or be a symbol.
      if (!consumed) begin
         if (is_operator(c)) begin
            t            = '0;
            t.word.kind  = KIND_SYMBOL;
            t.word.start = text_offset;
            t.word.len   = LEN_W'(1);
            t.word.line  = line_count;
            t.word.sym   = c;
            new_tokens.push_back(t);
         end else if (c == CHAR_QUOTE) begin
            begin_token(text_offset + 1'b1, SCAN_STRING);
         end else if (is_letter(c)) begin
            begin_token(text_offset, SCAN_WORD);
            take_char(c);
         end else if (is_digit(c)) begin
            begin_token(text_offset, SCAN_NUMBER);
            take_char(c);
         end
      end

      if (c == CHAR_LF && line_count != '1)
         line_count = line_count + 1'b1;

      // The final byte flushes an open token and starts a fresh text.
      if (eot) begin
         if (scan_state != SCAN_IDLE)
            finish_token();
         restart_text();
      end else begin
         text_offset = text_offset + 1'b1;
      end

      if (new_tokens.size() > 0) begin
         t      = new_tokens.pop_back();
         t.last = 1'b1;
         new_tokens.push_back(t);
      end
      foreach (new_tokens[i])
         tokens_due.push_back(new_tokens[i]);
   endtask

   task automatic check_field(input string field_name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
         fail_count++;
      end
   endtask

   task automatic compare_token(input token_word_type got, input logic got_last);
      token_expect_type want;
      want = tokens_due.pop_front();
      check_field("token_kind", 32'(want.word.kind), 32'(got.kind));
      check_field("start_position", 32'(want.word.start), 32'(got.start));
      check_field("token_length", 32'(want.word.len), 32'(got.len));
      check_field("start_line", 32'(want.word.line), 32'(got.line));
      check_field("symbol_byte", 32'(want.word.sym), 32'(got.sym));
      check_field("keyword_index", 32'(want.word.kwi), 32'(got.kwi));
      check_field("length_overflow", 32'(want.word.ovf), 32'(got.ovf));
      check_field("last_of_run", 32'(want.last), 32'(got_last));
      checked_count++;
      kind_mask[want.word.kind]   = 1'b1;
      keyword_mask[want.word.kwi] = 1'b1;
      if (want.word.ovf)
         long_count++;
      if (want.word.line > line_peak)
         line_peak = want.word.line;
   endtask

   // Token words are checked before the byte of the same edge is predicted;
   // a byte's tokens pass the queue and the output register before they appear.
   always @(posedge clock) begin
      if (reset) begin
         tokens_due.delete();
         restart_text();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (tokens_due.size() == 0) begin
               $error("unexpected token word 0x%0h", rsp_tdata);
               fail_count++;
            end else begin
               compare_token(rsp_tdata[TOK_W-1:0], rsp_tlast);
            end
         end
         if (req_tvalid && req_tready)
            scan_byte(req_tdata, req_tlast);
      end
      failures        <= fail_count;
      pending         <= tokens_due.size();
      tokens_checked  <= checked_count;
      overflow_tokens <= long_count;
      kinds_seen      <= kind_mask;
      keywords_seen   <= keyword_mask;
      top_line        <= line_peak;
   end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer testbench
// Feeds source text to the tokenizer: a short hand-written text, a run over
// many lines, over-long tokens, then random texts of keywords, names,
// numbers, strings, symbols and noise, under changing sender gaps and
// receiver stalls. The token checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench
   import stt_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEN      = MAX_TOKEN_LENGTH_DEF;
   localparam int TOK_W        = KIND_BITS + POSITION_BITS_DEF +
                                 $clog2(MAX_TOKEN_LENGTH_DEF + 1) + LINE_BITS_DEF +
                                 SYM_BITS + KWI_BITS + 1;
   localparam int DATA_W       = ((TOK_W + 7) / 8) * 8;
   localparam int RANDOM_BYTES = 1100;
   localparam int PHASE_BYTES  = 150;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   typedef enum logic [1:0] {
      PHASE_STEADY,
      PHASE_SENDER_IDLE,
      PHASE_RECEIVER_STALL,
      PHASE_BOTH
   } idle_phase_type;

   typedef enum int {
      LONG_WORD,
      LONG_NUMBER,
      LONG_STRING
   } long_kind_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tlast;

   int         failures;
   int         pending;
   int         tokens_checked;
   int         overflow_tokens;
   logic [5:0] kinds_seen;
   logic [5:0] keywords_seen;
   logic [15:0] top_line;

   int          idle_pct   = 0;
   int          stall_pct  = 0;
   int          bytes_sent = 0;
   logic [7:0]  text_bytes[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   source_text_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   token_checker #(
      .DATA_W (DATA_W)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .failures        (failures),
      .pending         (pending),
      .tokens_checked  (tokens_checked),
      .overflow_tokens (overflow_tokens),
      .kinds_seen      (kinds_seen),
      .keywords_seen   (keywords_seen),
      .top_line        (top_line)
   );

   // Receiver: take or stall each cycle at the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Text generation.
   function automatic logic [7:0] random_letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'(CHAR_LOWER_A + r);
      if (r < 52) return 8'(CHAR_UPPER_A + (r - 26));
      return CHAR_UNDERSCORE;
   endfunction

   function automatic logic [7:0] random_name_char();
      if ($urandom_range(0, 62) < 53) return random_letter();
      return 8'(CHAR_DIGIT_0 + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] random_space();
      case ($urandom_range(0, 3))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   function automatic logic [7:0] random_symbol();
      case ($urandom_range(0, 7))
         0: return CHAR_LPAREN;
         1: return CHAR_RPAREN;
         2: return CHAR_EQUAL;
         3: return CHAR_SEMI;
         4: return CHAR_PLUS;
         5: return CHAR_MINUS;
         6: return CHAR_SLASH;
         default: return CHAR_STAR;
      endcase
   endfunction

   // String content: mostly printable, with some newlines and high bytes.
   function automatic logic [7:0] random_string_char();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0: c = CHAR_LF;
         1: c = 8'($urandom_range(128, 255));
         default: c = 8'($urandom_range(32, 126));
      endcase
      if (c == CHAR_QUOTE)
         c = CHAR_UNDERSCORE;
      return c;
   endfunction

   // Keywords and words that nearly match one.
   function automatic string pick_word(input int k);
      case (k)
         0: return "var";
         1: return "print";
         2: return "const";
         3: return "string";
         4: return "int";
         5: return "va";
         6: return "vars";
         7: return "prin";
         8: return "Print";
         9: return "consts";
         10: return "in_t";
         default: return "strings";
      endcase
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         text_bytes.push_back(s[i]);
   endtask

   task automatic add_name(input int n);
      text_bytes.push_back(random_letter());
      repeat (n - 1) text_bytes.push_back(random_name_char());
   endtask

   task automatic add_number(input int n);
      repeat (n) text_bytes.push_back(8'(CHAR_DIGIT_0 + $urandom_range(0, 9)));
   endtask

   task automatic add_string(input int n, input logic closed);
      text_bytes.push_back(CHAR_QUOTE);
      repeat (n) text_bytes.push_back(random_string_char());
      if (closed)
         text_bytes.push_back(CHAR_QUOTE);
   endtask

   task automatic add_long_token(input long_kind_type kind, input int n);
      case (kind)
         LONG_WORD:   add_name(n);
         LONG_NUMBER: add_number(n);
         default:     add_string(n, 1'b1);
      endcase
      text_bytes.push_back(random_space());
   endtask

   // One random text: mostly well-formed token sequences, some pure noise.
   task automatic build_text();
      int target;
      int pick;
      text_bytes.delete();
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(5, 30)) text_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         target = $urandom_range(5, 60);
         if ($urandom_range(0, 15) == 0)
            add_long_token(long_kind_type'($urandom_range(0, 2)),
                           MAX_LEN - 1 + $urandom_range(0, 2));
         while (text_bytes.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
               push_text(pick_word($urandom_range(0, 11)));
            else if (pick < 35)
               add_name($urandom_range(1, 10));
            else if (pick < 47)
               add_number($urandom_range(1, 8));
            else if (pick < 57)
               add_string($urandom_range(0, 12), 1'b1);
            else if (pick < 84)
               text_bytes.push_back(random_symbol());
            else if (pick < 90)
               text_bytes.push_back(8'($urandom_range(0, 255)));
            else
               text_bytes.push_back(random_space());
            if ($urandom_range(0, 9) < 5)
               text_bytes.push_back(random_space());
         end
         // Now and then the text ends inside a token.
         case ($urandom_range(0, 5))
            0: add_string($urandom_range(0, 4), 1'b0);
            1: add_name($urandom_range(1, 4));
            2: add_number($urandom_range(1, 4));
            default: ;
         endcase
      end
   endtask

   // Byte driver. The valid is lowered only for a gap or a drain, so it is
   // never lowered and raised within one time step.
   task automatic send_byte(input logic [7:0] c, input logic eot);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(0, 99) < idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic drive_text();
      for (int i = 0; i < text_bytes.size(); i++)
         send_byte(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   task automatic drain_tokens();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic set_idling(input idle_phase_type phase);
      case (phase)
         PHASE_STEADY: begin
            idle_pct  = 0;
            stall_pct <= 0;
         end
         PHASE_SENDER_IDLE: begin
            idle_pct  = 57;
            stall_pct <= 0;
         end
         PHASE_RECEIVER_STALL: begin
            idle_pct  = 0;
            stall_pct <= 57;
         end
         default: begin
            idle_pct  = 16;
            stall_pct <= 16;
         end
      endcase
   endtask

   initial begin
      int             random_bytes;
      idle_phase_type phase;
      idle_phase_type last_phase;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Hand-written text: keywords, symbols after words and numbers, an
      // empty string, skipped bytes, and a quote on the final byte that
      // closes a number and opens a string flushed at once.
      push_text("var a1=90;\n");
      text_bytes.push_back(CHAR_CR);
      push_text("\"\"_(+-/*)");
      text_bytes.push_back(8'hFF);
      push_text("7\"");
      drive_text();
      text_bytes.delete();
      push_text("q");
      drive_text();
      drain_tokens();

      // Tokens spread over many lines.
      text_bytes.delete();
      push_text("a");
      repeat (40) text_bytes.push_back(CHAR_LF);
      push_text("b;");
      drive_text();

      // Tokens at and beyond the maximum length.
      text_bytes.delete();
      add_long_token(LONG_WORD, MAX_LEN + 1);
      add_long_token(LONG_NUMBER, MAX_LEN);
      add_long_token(LONG_STRING, MAX_LEN + 40);
      push_text("x=1");
      drive_text();
      drain_tokens();

      // Random texts, cycling through the idling phases.
      random_bytes = 0;
      last_phase   = PHASE_BOTH;
      while (random_bytes < RANDOM_BYTES) begin
         phase = idle_phase_type'((random_bytes / PHASE_BYTES) % 4);
         if (phase != last_phase) begin
            set_idling(phase);
            if (phase == PHASE_STEADY)
               drain_tokens();
            last_phase = phase;
         end
         build_text();
         drive_text();
         random_bytes += text_bytes.size();
      end

      set_idling(PHASE_STEADY);
      drain_tokens();
      repeat (10) @(posedge clock);

      $display("Sent %0d text bytes and checked %0d tokens, %0d of them over-long.",
               bytes_sent, tokens_checked, overflow_tokens);
      $display("Token kinds seen %b, keyword indexes seen %b, highest line %0d.",
               kinds_seen, keywords_seen, top_line);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #10ms;
      $display("status: fail");
      $finish;
   end

endmodule
